### sv/sid_pkg.sv
// ----------------------------------------------------------------------------
// sid_pkg
// Shared widths, character codes and defaults for the signed integer to
// padded decimal text converter.
// ----------------------------------------------------------------------------
package sid_pkg;

  // field widths of a request and a result
  localparam int VALUE_W     = 32;
  localparam int FIELD_W     = 6;
  localparam int CHAR_W      = 8;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 8;

  // bcd digit row: a 32-bit magnitude needs ten decimal digits
  localparam int NUM_DIGITS = 10;
  localparam int DIGIT_W    = 4;
  localparam int DIG_IDX_W  = $clog2(NUM_DIGITS);

  // default saturation limit for the width and zero-count minimums
  localparam int MAX_FIELD_DEF = 32;

  // ascii codes
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

endpackage

### sv/sid_bcd_cell.sv
// ----------------------------------------------------------------------------
// sid_bcd_cell
// One decimal digit of the shift-and-add-3 converter. Holds a bcd digit,
// takes a bit from its lower neighbour and passes its top bit upward.
// ----------------------------------------------------------------------------
module sid_bcd_cell (
  input  logic                        clk,
  input  logic                        clear,
  input  logic                        shift,
  input  logic                        bit_in,
  output logic                        bit_out,
  output logic [sid_pkg::DIGIT_W-1:0] digit
);
  import sid_pkg::*;

  logic [DIGIT_W-1:0] adj;

  // add 3 when the digit would reach ten or more after doubling
  always_comb begin
    adj     = (digit >= DIGIT_W'(5)) ? digit + DIGIT_W'(3) : digit;
    bit_out = adj[DIGIT_W-1];
  end

  // digit register, doubled with the neighbour's bit each step
  always_ff @(posedge clk) begin
    if (clear) begin
      digit <= '0;
    end else if (shift) begin
      digit <= {adj[DIGIT_W-2:0], bit_in};
    end
  end

endmodule

### sv/signed_int_to_padded_decimal_top.sv
// ----------------------------------------------------------------------------
// signed_int_to_padded_decimal_top
// Converts a signed 32-bit value to space and zero padded decimal ascii,
// one character per result, leftmost first, with tlast on the final one.
// ----------------------------------------------------------------------------
// a request is taken only in idle, and the next one only after the last
//   character of the text is loaded; in between come the 32-step bit-serial
//   walk through the digit row, a prep state and the one-character-per-cycle
//   output, which stalls while m_tready is low with a character held
// reset: rst clears the sequencer and the output valid; digits need no reset
module signed_int_to_padded_decimal_top #(
  parameter int MAX_FIELD = sid_pkg::MAX_FIELD_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // value [31:0], total width [37:32], zero digits [43:38], zero fill above
  input  logic [sid_pkg::IN_TDATA_W-1:0]  s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // character [7:0]
  output logic [sid_pkg::OUT_TDATA_W-1:0] m_tdata,
  output logic                            m_tlast
);
  import sid_pkg::*;

  localparam int CW  = $clog2(MAX_FIELD + 2);
  localparam int BCW = $clog2(VALUE_W);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_PREP = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]         state;
  logic [VALUE_W-1:0] mag;
  logic [BCW-1:0]     bit_cnt;
  logic               neg;
  logic [CW-1:0]      width_sat;
  logic [CW-1:0]      zeros_sat;
  logic [CW-1:0]      dz;
  logic [CW-1:0]      pos;

  logic               accept;
  logic               out_free;
  logic               load_out;
  logic [VALUE_W-1:0] raw;
  logic [FIELD_W-1:0] raw_width;
  logic [FIELD_W-1:0] raw_zeros;
  logic [CW-1:0]      nd;
  logic [CW-1:0]      dz_next;
  logic [CW-1:0]      sgn_len;
  logic [CW-1:0]      total;
  logic [CHAR_W-1:0]  ch;

  logic [DIGIT_W-1:0] digits [NUM_DIGITS];
  logic               carry  [NUM_DIGITS];

  function automatic logic [CW-1:0] sat_field(input logic [FIELD_W-1:0] x);
    if (x > FIELD_W'(MAX_FIELD)) begin
      return CW'(MAX_FIELD);
    end else begin
      return CW'(x);
    end
  endfunction

  assign raw       = s_tdata[VALUE_W-1:0];
  assign raw_width = s_tdata[VALUE_W+FIELD_W-1:VALUE_W];
  assign raw_zeros = s_tdata[VALUE_W+2*FIELD_W-1:VALUE_W+FIELD_W];

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign load_out = (state == ST_EMIT) && out_free;

  // row of bcd cells, units digit first, fed msb first from the magnitude
  genvar g;
  generate
    for (g = 0; g < NUM_DIGITS; g++) begin : g_cell
      if (g == NUM_DIGITS - 1) begin : g_top
        sid_bcd_cell u_cell (
          .clk     (clk),
          .clear   (accept),
          .shift   (state == ST_CONV),
          .bit_in  (carry[g-1]),
          .bit_out (),
          .digit   (digits[g])
        );
        assign carry[g] = 1'b0;
      end else if (g == 0) begin : g_units
        sid_bcd_cell u_cell (
          .clk     (clk),
          .clear   (accept),
          .shift   (state == ST_CONV),
          .bit_in  (mag[VALUE_W-1]),
          .bit_out (carry[g]),
          .digit   (digits[g])
        );
      end else begin : g_mid
        sid_bcd_cell u_cell (
          .clk     (clk),
          .clear   (accept),
          .shift   (state == ST_CONV),
          .bit_in  (carry[g-1]),
          .bit_out (carry[g]),
          .digit   (digits[g])
        );
      end
    end
  endgenerate

  // significant digit count and total text length
  always_comb begin
    nd = CW'(1);
    for (int i = 1; i < NUM_DIGITS; i++) begin
      if (digits[i] != '0) begin
        nd = CW'(i + 1);
      end
    end
    dz_next = (nd > zeros_sat) ? nd : zeros_sat;
    sgn_len = dz_next + CW'(neg);
    total   = (sgn_len > width_sat) ? sgn_len : width_sat;
  end

  // character at the current position, counted from the right
  always_comb begin
    if (pos < dz) begin
      if (pos < CW'(NUM_DIGITS)) begin
        ch = CH_ZERO + CHAR_W'(digits[pos[DIG_IDX_W-1:0]]);
      end else begin
        ch = CH_ZERO;
      end
    end else if (neg && (pos == dz)) begin
      ch = CH_MINUS;
    end else begin
      ch = CH_SPACE;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_CONV;
          end
        end
        ST_CONV: begin
          if (bit_cnt == BCW'(VALUE_W - 1)) begin
            state <= ST_PREP;
          end
        end
        ST_PREP: begin
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (load_out && (pos == '0)) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // request capture, magnitude shifter and position counter
  always_ff @(posedge clk) begin
    if (accept) begin
      neg       <= raw[VALUE_W-1];
      mag       <= raw[VALUE_W-1] ? (VALUE_W'(0) - raw) : raw;
      width_sat <= sat_field(raw_width);
      zeros_sat <= sat_field(raw_zeros);
      bit_cnt   <= '0;
    end else if (state == ST_CONV) begin
      mag     <= {mag[VALUE_W-2:0], 1'b0};
      bit_cnt <= bit_cnt + BCW'(1);
    end
    if (state == ST_PREP) begin
      dz  <= dz_next;
      pos <= total - CW'(1);
    end else if (load_out) begin
      pos <= pos - CW'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= ch;
      m_tlast <= (pos == '0);
    end
  end

endmodule

### tb/signed_int_to_padded_decimal_top_test.sv
// ----------------------------------------------------------------------------
// signed_int_to_padded_decimal_top_test
// Self-checking bench for the signed integer to padded decimal text block.
// Requests go in from a queue through a clocked driver. A clocked monitor
// checks every character and its tlast flag, in order, against text that
// an in-bench formatter predicts. The run passes through four flow-control
// phases with random idle and stall cycles.
// ----------------------------------------------------------------------------
module signed_int_to_padded_decimal_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import sid_pkg::*;

  localparam int MAX_FIELD  = MAX_FIELD_DEF;
  localparam int N_RANDOM   = 200;
  localparam int CYCLE_CAP  = 400000;
  localparam int DRAIN_WAIT = 80;

  // one conversion request plus its flow-control phase and drain flag
  typedef struct {
    logic [VALUE_W-1:0] value;
    logic [FIELD_W-1:0] total_width;
    logic [FIELD_W-1:0] zero_digits;
    int unsigned        phase;
    bit                 hold;
  } conv_req_t;

  // one predicted character of the text
  typedef struct {
    logic [CHAR_W-1:0] ch;
    logic              last;
    int                req_idx;
  } text_char_t;

  logic                   clk      = 1'b0;
  logic                   rst      = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata  = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tlast;

  conv_req_t  req_q[$];
  text_char_t text_q[$];
  conv_req_t  cur_req;
  int unsigned phase = 0;

  // sender idle and receiver stall chances per phase, in percent
  int unsigned gap_pct[4]   = '{0, 52, 0, 33};
  int unsigned stall_pct[4] = '{0, 0, 52, 33};

  int cycle_cnt   = 0;
  int n_total     = 0;
  int n_accepted  = 0;
  int n_chars     = 0;
  int n_errors    = 0;
  int n_negative  = 0;
  int n_saturated = 0;
  int longest     = 0;

  signed_int_to_padded_decimal_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // reset release and run timeout
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == 11) begin
      rst <= 1'b0;
    end
    if (cycle_cnt == CYCLE_CAP) begin
      $display("timeout: %0d of %0d requests taken, %0d characters still due",
               n_accepted, n_total, text_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic void add_req(input logic [VALUE_W-1:0] v, input int w, input int z,
                                  input int unsigned ph, input bit hold);
    conv_req_t r;
    r.value       = v;
    r.total_width = w[FIELD_W-1:0];
    r.zero_digits = z[FIELD_W-1:0];
    r.phase       = ph;
    r.hold        = hold;
    req_q.push_back(r);
  endfunction

  function automatic void flag_error(input string msg);
    if (n_errors < 10) begin
      $display("mismatch at cycle %0d: %s", cycle_cnt, msg);
    end
    n_errors++;
  endfunction

  // formats one request into the characters it must produce
  function automatic void predict_text(input conv_req_t r, input int idx);
    logic [VALUE_W-1:0] mag;
    logic               neg;
    logic [3:0]         dig[NUM_DIGITS];
    logic [CHAR_W-1:0]  ch;
    int                 width, zeros, ndig, shown, pad, n, k, pos;
    text_char_t         t;
    neg   = r.value[VALUE_W-1];
    mag   = neg ? (32'd0 - r.value) : r.value;
    width = (r.total_width > MAX_FIELD) ? MAX_FIELD : int'(r.total_width);
    zeros = (r.zero_digits > MAX_FIELD) ? MAX_FIELD : int'(r.zero_digits);
    // digits of the magnitude, least significant first; zero gives one digit
    ndig = 0;
    do begin
      dig[ndig] = 4'(mag % 32'd10);
      mag       = mag / 32'd10;
      ndig++;
    end while (mag != 0);
    shown = (zeros > ndig) ? zeros : ndig;
    pad   = (width > shown + neg) ? width - shown - neg : 0;
    n     = pad + neg + shown;
    // spaces, sign, zero fill, digits
    for (k = 0; k < n; k++) begin
      pos = n - 1 - k;
      if (k < pad) begin
        ch = CH_SPACE;
      end else if (neg && k == pad) begin
        ch = CH_MINUS;
      end else if (pos < ndig) begin
        ch = CH_ZERO + CHAR_W'(dig[pos]);
      end else begin
        ch = CH_ZERO;
      end
      t.ch      = ch;
      t.last    = (k == n - 1);
      t.req_idx = idx;
      text_q.push_back(t);
    end
    if (neg) n_negative++;
    if (r.total_width > MAX_FIELD || r.zero_digits > MAX_FIELD) n_saturated++;
    if (n > longest) longest = n;
  endfunction

  function automatic int unsigned pow10(input int e);
    int unsigned p;
    p = 1;
    for (int i = 0; i < e; i++) p = p * 10;
    return p;
  endfunction

  // value mix: full range, small, around powers of ten, extremes, shifted
  function automatic logic [VALUE_W-1:0] rand_value();
    logic [VALUE_W-1:0] v;
    case ($urandom_range(5))
      0: v = $urandom;
      1: v = $urandom_range(2000) - 1000;
      2: begin
        v = pow10($urandom_range(9)) + $urandom_range(2) - 1;
        if ($urandom_range(1)) v = 32'd0 - v;
      end
      3: case ($urandom_range(4))
        0: v = 32'h8000_0000;
        1: v = 32'h7fff_ffff;
        2: v = 32'h8000_0001;
        3: v = 32'hffff_ffff;
        default: v = 32'h0;
      endcase
      default: v = $signed($urandom) >>> $urandom_range(31);
    endcase
    return v;
  endfunction

  function automatic int rand_field();
    return ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(12);
  endfunction

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_text(cur_req, n_accepted);
        n_accepted++;
      end
      if (!s_tvalid || s_tready) begin
        if (req_q.size() != 0 && $urandom_range(99) >= gap_pct[phase] &&
            !(req_q[0].hold && text_q.size() != 0)) begin
          cur_req = req_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {4'b0, cur_req.zero_digits, cur_req.total_width, cur_req.value};
          phase    <= cur_req.phase;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver back-pressure
  always @(posedge clk) begin
    text_char_t e;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (text_q.size() == 0) begin
          flag_error($sformatf("unexpected character %h tlast %b", m_tdata, m_tlast));
        end else begin
          e = text_q.pop_front();
          if (m_tdata !== e.ch) begin
            flag_error($sformatf("request %0d character: expected %h got %h",
                                 e.req_idx, e.ch, m_tdata));
          end
          if (m_tlast !== e.last) begin
            flag_error($sformatf("request %0d tlast: expected %b got %b",
                                 e.req_idx, e.last, m_tlast));
          end
          n_chars++;
        end
      end
      m_tready <= ($urandom_range(99) >= stall_pct[phase]);
    end
  end

  // stimulus and end of run
  initial begin
    // directed: zero, extremes, sign and padding corners, saturation
    add_req(32'd0,          0,  0,  0, 0);
    add_req(32'd0,          1,  1,  0, 0);
    add_req(32'd0,          32, 32, 0, 0);
    add_req(32'h8000_0000,  0,  0,  0, 0);
    add_req(32'h8000_0000,  63, 63, 0, 0);
    add_req(32'h7fff_ffff,  0,  0,  0, 0);
    add_req(32'h7fff_ffff,  11, 10, 0, 0);
    add_req(32'hffff_ffff,  0,  0,  0, 0);
    add_req(32'd1,          5,  3,  0, 0);
    add_req(-12345,         10, 8,  0, 0);
    add_req(32'd9,          0,  0,  0, 0);
    add_req(32'd10,         2,  0,  0, 1);
    add_req(-10,            3,  2,  0, 0);
    add_req(32'd999999999,  0,  0,  0, 0);
    add_req(32'd1000000000, 0,  0,  0, 0);
    add_req(-1000000000,    12, 11, 0, 0);
    add_req(32'd42,         33, 0,  0, 0);
    add_req(-7,             1,  1,  0, 0);
    add_req(32'd123,        2,  2,  0, 0);
    add_req(-5,             40, 0,  0, 0);
    add_req(32'd100,        0,  63, 0, 0);
    add_req(32'h8000_0001,  32, 0,  0, 0);
    add_req(-99,            0,  33, 0, 1);
    // random, spread over the four flow-control phases
    for (int i = 0; i < N_RANDOM; i++) begin
      add_req(rand_value(), rand_field(), rand_field(), i * 4 / N_RANDOM,
              (i % (N_RANDOM / 4) == 0) || ($urandom_range(29) == 0));
    end
    n_total = req_q.size();

    do @(negedge clk); while (n_accepted != n_total || text_q.size() != 0);
    repeat (DRAIN_WAIT) @(negedge clk);

    $display("converted %0d values (%0d negative, %0d with saturated minimums)",
             n_accepted, n_negative, n_saturated);
    $display("checked %0d characters, longest text %0d, %0d mismatches",
             n_chars, longest, n_errors);
    if (n_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
